// ===== rtl/core/hysteresis_pulse_rate_meter_assert.svh =====
// assertion macros used by hysteresis_pulse_rate_meter.sv
`ifndef HYSTERESIS_PULSE_RATE_METER_ASSERT_SVH
`define HYSTERESIS_PULSE_RATE_METER_ASSERT_SVH

`ifndef SYNTHESIS
`define HPRM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HPRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPRM_ASSERT_IMPLIES(label, ante, cons)
`define HPRM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/hprm_pkg.sv =====
package hprm_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int TIME_BITS           = 32;
    localparam int WINDOW_BITS         = 16;
    localparam int CFG_DATA_BITS       = 16;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int OUT_COUNT_BITS      = 7;

    localparam int HIGH_RESET   = 2500;
    localparam int LOW_RESET    = 1500;
    localparam int WINDOW_RESET = 1000;

    localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = 7'd127;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MS      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM,
        ST_DONE
    } hprm_state_t;

    typedef struct packed {
        logic shift_stamp;
        logic load_hit;
        logic shift_hit;
    } hprm_cell_ctrl_t;

endpackage

// ===== rtl/core/hprm_cell.sv =====
module hprm_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hprm_pkg::hprm_cell_ctrl_t           ctrl,
    input  logic                                stored,
    input  logic [hprm_pkg::TIME_BITS-1:0]      stamp_in,
    input  logic [hprm_pkg::TIME_BITS-1:0]      now,
    input  logic [hprm_pkg::WINDOW_BITS-1:0]    window,
    input  logic                                hit_in,
    output logic [hprm_pkg::TIME_BITS-1:0]      stamp_out,
    output logic                                hit_out
);
    import hprm_pkg::*;

    logic [TIME_BITS-1:0] stamp_reg;
    logic                 hit_reg;
    logic                 hit_next;
    logic [TIME_BITS-1:0] age;

    // age wraps modulo 2^32, so future stamps look very old
    assign age = now - stamp_reg;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.load_hit)
        begin
            hit_next = stored && (age <= TIME_BITS'(window));
        end
        else if (ctrl.shift_hit)
        begin
            hit_next = hit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_stamp)
        begin
            stamp_reg <= stamp_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign stamp_out = stamp_reg;
    assign hit_out   = hit_reg;

endmodule

// ===== rtl/core/hysteresis_pulse_rate_meter.sv =====
// Hysteresis pulse-rate meter. Each sample goes through a Schmitt comparator
// (rise at or above high_threshold, fall at or below low_threshold); every
// rise pushes time_ms into a chain of DEPTH stamp cells, newest at the head,
// and the stored count saturates at DEPTH. For each sample the block returns
// the level, the pulse flag and the number of stored pulses with
// time_ms - stamp (mod 2^32) <= window_ms, saturated at 127. A sample is
// taken only in the idle state; in_stall holds off the next one while all
// cells compare their stamps in parallel (evaluate state), the hit bits
// drain down the chain into a serial tally (sum state) and the output
// register is loaded once free or not stalled (done state). The result
// waits in that register while the next sample is taken in. The block does
// not hold off configuration writes; write registers only while no sample is
// in flight, and a write takes effect at the clock edge that takes it.
`include "hysteresis_pulse_rate_meter_assert.svh"

module hysteresis_pulse_rate_meter #(
    parameter int DEPTH       = hprm_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = hprm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [hprm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [hprm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [SAMPLE_BITS-1:0]                  sample,
    input  logic [hprm_pkg::TIME_BITS-1:0]          time_ms,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    level_high,
    output logic                                    pulse_seen,
    output logic [hprm_pkg::OUT_COUNT_BITS-1:0]     pulses_in_window
);
    import hprm_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);

    logic [SAMPLE_BITS-1:0] high_thr_reg;
    logic [SAMPLE_BITS-1:0] low_thr_reg;
    logic [WINDOW_BITS-1:0] window_reg;

    hprm_state_t state_reg, state_next;
    logic        level_reg, level_next;
    logic        pulse_reg, pulse_next;
    logic [CNT_W-1:0]     stored_reg, stored_next;
    logic [CNT_W-1:0]     tally_reg, tally_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [TIME_BITS-1:0] now_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_level_reg;
    logic                      out_pulse_reg;
    logic [OUT_COUNT_BITS-1:0] out_count_reg;
    logic                      out_load;

    logic in_fire;
    logic pulse_now;
    hprm_cell_ctrl_t cell_ctrl;

    logic [TIME_BITS-1:0] stamp_chain [DEPTH+1];
    logic [DEPTH:0]       hit_chain;
    logic [DEPTH-1:0]     cell_stored;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign pulse_now = !level_reg && (sample >= high_thr_reg);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= SAMPLE_BITS'(HIGH_RESET);
            low_thr_reg  <= SAMPLE_BITS'(LOW_RESET);
            window_reg   <= WINDOW_BITS'(WINDOW_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_WINDOW_MS:      window_reg   <= cfg_data[WINDOW_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // stamp cell chain, newest stamp at cell 0
    assign stamp_chain[0] = time_ms;
    assign hit_chain[0]   = 1'b0;

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            assign cell_stored[g] = (CNT_W'(g) < stored_reg);

            hprm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .stored    (cell_stored[g]),
                .stamp_in  (stamp_chain[g]),
                .now       (now_reg),
                .window    (window_reg),
                .hit_in    (hit_chain[g]),
                .stamp_out (stamp_chain[g+1]),
                .hit_out   (hit_chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        pulse_next  = pulse_reg;
        stored_next = stored_reg;
        tally_next  = tally_reg;
        step_next   = step_reg;
        out_load    = 1'b0;
        cell_ctrl   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pulse_next = pulse_now;
                    if (pulse_now)
                    begin
                        level_next            = 1'b1;
                        cell_ctrl.shift_stamp = 1'b1;
                        if (stored_reg != CNT_W'(DEPTH))
                        begin
                            stored_next = stored_reg + CNT_W'(1);
                        end
                    end
                    else if (level_reg && (sample <= low_thr_reg))
                    begin
                        level_next = 1'b0;
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cell_ctrl.load_hit = 1'b1;
                tally_next = '0;
                step_next  = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // tail cell's hit bit drops into the tally each cycle
                cell_ctrl.shift_hit = 1'b1;
                tally_next = tally_reg + CNT_W'(hit_chain[DEPTH]);
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= 1'b0;
            pulse_reg     <= 1'b0;
            stored_reg    <= '0;
            tally_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            pulse_reg     <= pulse_next;
            stored_reg    <= stored_next;
            tally_reg     <= tally_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg <= time_ms;
        end
        if (out_load)
        begin
            out_level_reg <= level_reg;
            out_pulse_reg <= pulse_reg;
            if (32'(tally_reg) > 32'(OUT_COUNT_MAX))
            begin
                out_count_reg <= OUT_COUNT_MAX;
            end
            else
            begin
                out_count_reg <= OUT_COUNT_BITS'(tally_reg);
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign level_high       = out_level_reg;
    assign pulse_seen       = out_pulse_reg;
    assign pulses_in_window = out_count_reg;

    `HPRM_ASSERT_IMPLIES(a_stored_max, 1'b1, stored_reg <= CNT_W'(DEPTH))
    `HPRM_ASSERT_NEXT(a_accept_eval, in_fire, state_reg == ST_EVAL)
    `HPRM_ASSERT_NEXT(a_pulse_count, in_fire && pulse_now && (stored_reg != CNT_W'(DEPTH)), stored_reg == $past(stored_reg) + CNT_W'(1))
    `HPRM_ASSERT_IMPLIES(a_tally_bound, state_reg == ST_DONE, tally_reg <= stored_reg)
    `HPRM_ASSERT_NEXT(a_load_valid, out_load, out_valid_reg && (state_reg == ST_IDLE))

endmodule
